// ===== rtl/core/gamepad_motion_aim_mixer_assert.svh =====
// Assertion macros for the motion aim mixer RTL.
// Clocked on clk; the reset-qualified form also assumes rst_n in scope.
`ifndef GAMEPAD_MOTION_AIM_MIXER_ASSERT_SVH
`define GAMEPAD_MOTION_AIM_MIXER_ASSERT_SVH

`ifndef SYNTHESIS
`define GMAM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gmam assertion failed");
`define GMAM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gmam assertion failed");
`else
`define GMAM_ASSERT(label, prop)
`define GMAM_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/core/gmam_pkg.sv =====
// Types and constants of the motion aim mixer.
// No dependencies; imported by gamepad_motion_aim_mixer.
package gmam_pkg;

    typedef enum logic [1:0] {
        MODE_DEFAULT = 2'd0,
        MODE_AIM     = 2'd1,
        MODE_WHEEL   = 2'd2
    } mode_t;

    localparam logic [1:0] REG_AIM_GAIN_X = 2'd0;
    localparam logic [1:0] REG_AIM_GAIN_Y = 2'd1;
    localparam logic [1:0] REG_WHEEL_GAIN = 2'd2;

    localparam int BTN_UP_BIT    = 0;
    localparam int BTN_START_BIT = 4;
    localparam int BTN_BACK_BIT  = 5;
    localparam int BTN_LSHLD_BIT = 8;
    localparam int BTN_RSHLD_BIT = 9;

    localparam int HALF_TURN  = 11520;
    localparam int AXIS_MAX   = 32767;
    localparam int FRAC_SHIFT = 14;

    localparam logic signed [15:0] AIM_GAIN_RESET   = -16'sd256;
    localparam logic [22:0]        WHEEL_GAIN_RESET = 23'd104858;

    typedef struct packed {
        logic [15:0]        buttons;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic               pad_ok;
        logic signed [14:0] pitch_angle;
        logic signed [14:0] roll_angle;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        out_buttons;
        logic [7:0]         out_left_trigger;
        logic [7:0]         out_right_trigger;
        logic signed [15:0] out_left_x;
        logic signed [15:0] out_left_y;
        logic signed [15:0] out_right_x;
        logic signed [15:0] out_right_y;
        logic               connected;
    } out_item_t;

    // truncating remainder by half a turn, sign follows the difference
    function automatic logic signed [14:0] rem_half_turn(input logic signed [15:0] d);
        logic [15:0] mag;
        logic [15:0] r;
        logic [14:0] rs;
        mag = d[15] ? 16'(-d) : 16'(d);
        if (mag >= 16'(2 * HALF_TURN))
        begin
            r = mag - 16'(2 * HALF_TURN);
        end
        else if (mag >= 16'(HALF_TURN))
        begin
            r = mag - 16'(HALF_TURN);
        end
        else
        begin
            r = mag;
        end
        rs = r[14:0];
        return d[15] ? -$signed(rs) : $signed(rs);
    endfunction

    // divide by 2^14 rounding half away from zero, saturate to +-32767
    function automatic logic signed [15:0] round_sat(input logic signed [39:0] t);
        logic [39:0] mag;
        logic [25:0] q;
        logic [14:0] qs;
        mag = t[39] ? 40'(-t) : 40'(t);
        q   = 26'((mag + 40'(1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT);
        qs  = (q > 26'(AXIS_MAX)) ? 15'(AXIS_MAX) : q[14:0];
        return t[39] ? 16'(-$signed({1'b0, qs})) : $signed({1'b0, qs});
    endfunction

endpackage

// ===== rtl/core/gamepad_motion_aim_mixer.sv =====
// Motion aim mixer top level: input register, one pass of chord, angle and
// stick logic, result register. Depends on gmam_pkg and the assertion header.
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tdata: pad report + angles, tuser: pad_ok
// m_*       out  tvalid/tready      tdata: adjusted report, tuser: connected
// APB       in   psel/penable       gains at 0x0, 0x4, 0x8
//
// One transfer per cycle sustained while m_tready stays high. An s transfer
// fills the input register, then, once it is free, the result register that
// drives m_tvalid. The path from input register to result register holds the
// remainder by 180 degrees, one multiplier deep, and the rounding saturation.
// s_tready follows m_tready combinationally when both registers are full.
// Reset clears mode, centres, valid flags and restores the gain defaults.
`include "gamepad_motion_aim_mixer_assert.svh"

module gamepad_motion_aim_mixer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // buttons, left_trigger, right_trigger, left_x, left_y, right_x, right_y,
    // pitch_angle, roll_angle; two unused pad bits on top
    input  logic [127:0] s_tdata,
    // pad_ok
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_buttons, out_left_trigger, out_right_trigger, out_left_x,
    // out_left_y, out_right_x, out_right_y
    output logic [95:0]  m_tdata,
    // connected
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import gmam_pkg::*;

    logic               in_vld_reg;
    logic               in_vld_next;
    in_item_t           in_data_reg;
    in_item_t           in_data_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;
    logic signed [15:0] aim_gain_x_reg;
    logic signed [15:0] aim_gain_y_reg;
    logic [22:0]        wheel_gain_reg;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic signed [14:0] pitch_centre_reg;
    logic signed [14:0] pitch_centre_next;
    logic signed [14:0] roll_centre_reg;
    logic signed [14:0] roll_centre_next;

    logic               s_xfer;
    logic               adv;
    logic               cfg_wr;
    logic               shoulders;
    logic               chord_back;
    logic               chord_start;
    logic               chord_up;
    logic               chord_hit;
    mode_t              mode_eff;
    logic signed [14:0] pitch_centre_eff;
    logic signed [14:0] roll_centre_eff;
    logic signed [14:0] d_pitch;
    logic signed [14:0] d_roll;
    logic signed [30:0] prod_x;
    logic signed [30:0] prod_y;
    logic signed [38:0] prod_w;
    logic signed [39:0] t_x;
    logic signed [39:0] t_y;
    logic signed [39:0] t_w;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;

    always_comb
    begin
        in_data_next.buttons       = s_tdata[15:0];
        in_data_next.left_trigger  = s_tdata[23:16];
        in_data_next.right_trigger = s_tdata[31:24];
        in_data_next.left_x        = s_tdata[47:32];
        in_data_next.left_y        = s_tdata[63:48];
        in_data_next.right_x       = s_tdata[79:64];
        in_data_next.right_y       = s_tdata[95:80];
        in_data_next.pad_ok        = s_tuser;
        in_data_next.pitch_angle   = s_tdata[110:96];
        in_data_next.roll_angle    = s_tdata[125:111];
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_xfer)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign shoulders   = in_data_reg.buttons[BTN_LSHLD_BIT] && in_data_reg.buttons[BTN_RSHLD_BIT];
    assign chord_back  = shoulders && in_data_reg.buttons[BTN_BACK_BIT];
    assign chord_start = shoulders && in_data_reg.buttons[BTN_START_BIT];
    assign chord_up    = shoulders && in_data_reg.buttons[BTN_UP_BIT];
    assign chord_hit   = chord_back || chord_start || chord_up;

    always_comb
    begin
        if (chord_back && chord_start)
        begin
            mode_eff = MODE_DEFAULT;
        end
        else if (chord_back)
        begin
            mode_eff = MODE_AIM;
        end
        else if (chord_start)
        begin
            mode_eff = MODE_WHEEL;
        end
        else
        begin
            mode_eff = mode_reg;
        end
    end

    assign pitch_centre_eff = chord_up ? in_data_reg.pitch_angle : pitch_centre_reg;
    assign roll_centre_eff  = chord_up ? in_data_reg.roll_angle : roll_centre_reg;

    assign d_pitch = rem_half_turn(16'(in_data_reg.pitch_angle) - 16'(pitch_centre_eff));
    assign d_roll  = rem_half_turn(16'(in_data_reg.roll_angle) - 16'(roll_centre_eff));

    assign prod_x = 31'(d_roll) * 31'(aim_gain_x_reg);
    assign prod_y = 31'(d_pitch) * 31'(aim_gain_y_reg);
    assign prod_w = 39'(d_roll) * $signed({16'd0, wheel_gain_reg});

    assign t_x = $signed({{10{in_data_reg.right_x[15]}}, in_data_reg.right_x, 14'd0})
                 + 40'(prod_x);
    assign t_y = $signed({{10{in_data_reg.right_y[15]}}, in_data_reg.right_y, 14'd0})
                 + 40'(prod_y);
    assign t_w = -40'(prod_w);

    always_comb
    begin
        mode_next         = mode_reg;
        pitch_centre_next = pitch_centre_reg;
        roll_centre_next  = roll_centre_reg;
        if (adv && in_data_reg.pad_ok)
        begin
            mode_next         = mode_eff;
            pitch_centre_next = pitch_centre_eff;
            roll_centre_next  = roll_centre_eff;
        end
    end

    always_comb
    begin
        out_data_next.out_buttons       = chord_hit ? 16'd0 : in_data_reg.buttons;
        out_data_next.out_left_trigger  = in_data_reg.left_trigger;
        out_data_next.out_right_trigger = in_data_reg.right_trigger;
        out_data_next.out_left_x        = in_data_reg.left_x;
        out_data_next.out_left_y        = in_data_reg.left_y;
        out_data_next.out_right_x       = in_data_reg.right_x;
        out_data_next.out_right_y       = in_data_reg.right_y;
        out_data_next.connected         = 1'b1;
        case (mode_eff)
            MODE_AIM:
            begin
                out_data_next.out_right_x = round_sat(t_x);
                out_data_next.out_right_y = round_sat(t_y);
            end
            MODE_WHEEL:
            begin
                out_data_next.out_left_x = round_sat(t_w);
            end
            default:
            begin
            end
        endcase
        if (!in_data_reg.pad_ok)
        begin
            out_data_next = '0;
        end
    end

    assign m_tdata = {out_data_reg.out_right_y, out_data_reg.out_right_x,
                      out_data_reg.out_left_y, out_data_reg.out_left_x,
                      out_data_reg.out_right_trigger, out_data_reg.out_left_trigger,
                      out_data_reg.out_buttons};
    assign m_tuser = out_data_reg.connected;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_AIM_GAIN_X: prdata = {16'd0, aim_gain_x_reg};
            REG_AIM_GAIN_Y: prdata = {16'd0, aim_gain_y_reg};
            REG_WHEEL_GAIN: prdata = {9'd0, wheel_gain_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aim_gain_x_reg <= AIM_GAIN_RESET;
            aim_gain_y_reg <= AIM_GAIN_RESET;
            wheel_gain_reg <= WHEEL_GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_AIM_GAIN_X: aim_gain_x_reg <= pwdata[15:0];
                REG_AIM_GAIN_Y: aim_gain_y_reg <= pwdata[15:0];
                REG_WHEEL_GAIN: wheel_gain_reg <= pwdata[22:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            mode_reg         <= MODE_DEFAULT;
            pitch_centre_reg <= '0;
            roll_centre_reg  <= '0;
        end
        else
        begin
            in_vld_reg       <= in_vld_next;
            out_vld_reg      <= out_vld_next;
            mode_reg         <= mode_next;
            pitch_centre_reg <= pitch_centre_next;
            roll_centre_reg  <= roll_centre_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_data_reg <= in_data_next;
        end
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `GMAM_ASSERT_ALWAYS(a_ready_only_when_full, !s_tready |-> in_vld_reg)
    `GMAM_ASSERT(a_disconnected_zero, (out_vld_reg && !m_tuser) |-> (m_tdata == '0))
    `GMAM_ASSERT(a_bad_pad_keeps_state,
        (adv && !in_data_reg.pad_ok) |=> ($stable(mode_reg) && $stable(pitch_centre_reg)
        && $stable(roll_centre_reg)))
    `GMAM_ASSERT(a_chord_clears_buttons,
        (adv && in_data_reg.pad_ok && chord_hit) |=> (m_tvalid && m_tdata[15:0] == 16'd0))

endmodule
